[rtl/gtd_pkg.sv]
package gtd_pkg;

  // Internal fixed-point formats: polynomial in Q24, tanh in Q30
  localparam longint ONE30 = 64'sd1073741824;

  localparam int XQ_W  = 29;  // clamped x, Q24, |x| <= 8
  localparam int X2_W  = 32;  // x^2, Q24
  localparam int X3_W  = 35;  // x^3, Q24
  localparam int U_W   = 31;  // x + a*x^3, Q24
  localparam int PL_W  = 29;  // 1 + 3a*x^2, Q24
  localparam int IN_W  = 31;  // tanh argument, Q24
  localparam int T_W   = 32;  // tanh, Q30
  localparam int H_W   = 26;  // (1+t)/2, Q24
  localparam int D_W   = 32;  // derivative, Q24
  localparam int FR_W  = 27;  // fraction within one table segment
  localparam int TAB_W = 32;  // table entry width

  // sqrt(2/pi), 0.044715 and 3*0.044715 in Q30
  localparam logic signed [30:0] K_C  = 31'sd856722024;
  localparam logic signed [26:0] K_A  = 27'sd48012366;
  localparam logic signed [28:0] K_A3 = 29'sd144037097;

  // tanh argument at which the table ends (8.0 in Q24)
  localparam logic [IN_W-1:0] RANGE24 = 31'd134217728;

  typedef enum logic {
    FUNC_FWD = 1'b0,
    FUNC_BWD = 1'b1
  } func_t;

  // unsigned quotient of n by d, restoring long division; elaboration only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f), f in Q30 with 0 <= f <= 1.0, result Q30; elaboration only
  function automatic longint exp_neg_frac(input longint unsigned f);
    longint unsigned term;
    longint          sum;
    term = longint'(ONE30);
    sum  = ONE30;
    for (int i = 1; i <= 24; i++) begin
      term = udiv((term * f) >> 30, longint'(i));
      if ((i & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

endpackage

[rtl/gtd_core.sv]
module gtd_core
  import gtd_pkg::*;
#(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TANH_SEGMENTS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_func,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_grad,
  output logic                         res_valid,
  output logic        [DATA_WIDTH-1:0] res_value,
  output logic                         res_sat
);

  localparam int DW    = DATA_WIDTH;
  localparam int FW    = DW + 2;            // forward result
  localparam int RW    = DW + 9;            // result before clipping
  localparam int KW    = $clog2(TANH_SEGMENTS + 1);
  localparam int P_W   = FR_W + KW;
  localparam int NST   = 11;

  localparam logic signed [39:0] LIM    = 40'(longint'(8) <<< FRAC_BITS);
  localparam logic signed [RW-1:0] R_HI = RW'((longint'(1) <<< (DW - 1)) - 1);
  localparam logic signed [RW-1:0] R_LO = RW'(-(longint'(1) <<< (DW - 1)));

  // tanh(8k/N) in Q30, k = 0..N, forced non-decreasing
  function automatic logic [TANH_SEGMENTS:0][TAB_W-1:0] build_tab();
    logic [TANH_SEGMENTS:0][TAB_W-1:0] tab;
    longint          e1;
    longint          e;
    longint          th;
    longint          prev;
    longint unsigned y;
    longint unsigned n;
    e1   = exp_neg_frac(longint'(ONE30));
    prev = 0;
    for (int k = 0; k <= TANH_SEGMENTS; k++) begin
      y = udiv(longint'(k) <<< 34, longint'(TANH_SEGMENTS));
      n = y >> 30;
      e = exp_neg_frac(y & 64'h3FFF_FFFF);
      for (longint unsigned i = 0; i < n; i++) begin
        e = (e * e1) >>> 30;
      end
      th = longint'(udiv((ONE30 - e) * ONE30, ONE30 + e));
      if (k > 0 && th < prev) begin
        th = prev;
      end
      tab[k] = TAB_W'(th);
      prev   = th;
    end
    return tab;
  endfunction

  localparam logic [TANH_SEGMENTS:0][TAB_W-1:0] TANH_TAB = build_tab();

  // valid bits and carried fields
  logic [NST:1]                valid_r;
  logic                        func_r [1:NST];
  logic signed [DW-1:0]        xv_r   [1:7];
  logic signed [DW-1:0]        gv_r   [1:NST];
  logic signed [XQ_W-1:0]      xq_r   [1:10];
  logic signed [PL_W-1:0]      pl_r   [3:9];
  logic signed [H_W-1:0]       h_r    [8:10];
  logic signed [FW-1:0]        fw_r   [8:NST];

  // stage registers
  logic signed [X2_W-1:0]      x2_r;
  logic signed [X3_W-1:0]      x3_r;
  logic signed [U_W-1:0]       u_r;
  logic signed [IN_W-1:0]      inner_r;
  logic                        neg_r;
  logic                        big_r;
  logic signed [T_W-1:0]       tk_r;
  logic signed [T_W-1:0]       dt_r;
  logic        [FR_W-1:0]      fr_r;
  logic signed [T_W-1:0]       t_r;
  logic signed [31:0]          s2_r;
  logic signed [31:0]          sc_r;
  logic signed [31:0]          q_r;
  logic signed [D_W-1:0]       d_r;

  // next values
  logic signed [39:0]          xw;
  logic signed [39:0]          xc;
  logic signed [XQ_W-1:0]      xq_nxt;
  logic signed [57:0]          x2_prod;
  logic signed [X2_W-1:0]      x2_nxt;
  logic signed [60:0]          x3_prod;
  logic signed [X3_W-1:0]      x3_nxt;
  logic signed [60:0]          pl_prod;
  logic signed [PL_W-1:0]      pl_nxt;
  logic signed [61:0]          ax3_prod;
  logic signed [61:0]          ax3;
  logic signed [U_W-1:0]       u_nxt;
  logic signed [61:0]          in_prod;
  logic signed [IN_W-1:0]      inner_nxt;
  logic                        neg_nxt;
  logic        [IN_W-1:0]      mag;
  logic                        big_nxt;
  logic        [P_W-1:0]       seg_pos;
  logic        [KW-1:0]        k_idx;
  logic        [KW-1:0]        k_inc;
  logic signed [T_W-1:0]       tk_nxt;
  logic signed [T_W-1:0]       dt_nxt;
  logic        [FR_W-1:0]      fr_nxt;
  logic signed [59:0]          ip_prod;
  logic signed [T_W-1:0]       t_mag;
  logic signed [T_W-1:0]       t_nxt;
  logic signed [32:0]          one_t;
  logic signed [DW+32:0]       fw_prod;
  logic signed [FW-1:0]        fw_nxt;
  logic signed [63:0]          tt_prod;
  logic signed [31:0]          s2_nxt;
  logic signed [H_W-1:0]       h_nxt;
  logic signed [62:0]          sc_prod;
  logic signed [31:0]          sc_nxt;
  logic signed [60:0]          q_prod;
  logic signed [31:0]          q_nxt;
  logic signed [60:0]          qx_prod;
  logic signed [D_W-1:0]       d_nxt;
  logic signed [DW+31:0]       gd_prod;
  logic signed [DW+31:0]       bres;
  logic signed [RW-1:0]        res_full;

  always_comb begin
    // S0 -> S1: clamp to [-8, 8] and move to Q24
    xw     = 40'(in_x);
    xc     = (xw > LIM) ? LIM : ((xw < -LIM) ? -LIM : xw);
    xq_nxt = XQ_W'(xc <<< (24 - FRAC_BITS));

    // S1 -> S2
    x2_prod = xq_r[1] * xq_r[1];
    x2_nxt  = X2_W'((x2_prod + (58'sd1 <<< 23)) >>> 24);

    // S2 -> S3: x^3 and the derivative polynomial
    x3_prod = x2_r * xq_r[2];
    x3_nxt  = X3_W'((x3_prod + (61'sd1 <<< 23)) >>> 24);
    pl_prod = K_A3 * x2_r;
    pl_nxt  = PL_W'((61'sd1 <<< 24) + ((pl_prod + (61'sd1 <<< 29)) >>> 30));

    // S3 -> S4
    ax3_prod = K_A * x3_r;
    ax3      = (ax3_prod + (62'sd1 <<< 29)) >>> 30;
    u_nxt    = U_W'(62'(xq_r[3]) + ax3);

    // S4 -> S5
    in_prod   = K_C * u_r;
    inner_nxt = IN_W'((in_prod + (62'sd1 <<< 29)) >>> 30);

    // S5 -> S6: segment select and table read
    neg_nxt = inner_r[IN_W-1];
    mag     = neg_nxt ? IN_W'(-inner_r) : IN_W'(inner_r);
    big_nxt = (mag >= RANGE24);
    seg_pos = P_W'(mag[FR_W-1:0]) * P_W'(TANH_SEGMENTS);
    k_idx   = seg_pos[P_W-1:FR_W];
    k_inc   = k_idx + KW'(1);
    fr_nxt  = seg_pos[FR_W-1:0];
    tk_nxt  = $signed(TANH_TAB[k_idx]);
    dt_nxt  = $signed(TANH_TAB[k_inc]) - $signed(TANH_TAB[k_idx]);

    // S6 -> S7: interpolate, restore sign
    ip_prod = dt_r * $signed({1'b0, fr_r});
    t_mag   = big_r ? T_W'(ONE30)
                    : tk_r + T_W'((ip_prod + (60'sd1 <<< 26)) >>> 27);
    t_nxt   = neg_r ? -t_mag : t_mag;

    // S7 -> S8: forward result, 1 - t^2, (1+t)/2
    one_t   = 33'(ONE30) + 33'(t_r);
    fw_prod = xv_r[7] * one_t;
    fw_nxt  = FW'((fw_prod + ((DW+33)'(1) <<< 30)) >>> 31);
    tt_prod = t_r * t_r;
    s2_nxt  = 32'(ONE30 - ((tt_prod + (64'sd1 <<< 29)) >>> 30));
    h_nxt   = H_W'((one_t + 33'sd64) >>> 7);

    // S8 -> S9
    sc_prod = s2_r * K_C;
    sc_nxt  = 32'((sc_prod + (63'sd1 <<< 29)) >>> 30);

    // S9 -> S10
    q_prod = sc_r * pl_r[9];
    q_nxt  = 32'((q_prod + (61'sd1 <<< 29)) >>> 30);

    // S10 -> S11
    qx_prod = q_r * xq_r[10];
    d_nxt   = D_W'(33'(h_r[10]) + 33'((qx_prod + (61'sd1 <<< 24)) >>> 25));

    // S11 out: gradient product, mode select, clip
    gd_prod  = gv_r[NST] * d_r;
    bres     = (gd_prod + ((DW+32)'(1) <<< 23)) >>> 24;
    res_full = (func_r[NST] == FUNC_BWD) ? RW'(bres) : RW'(fw_r[NST]);
    if (res_full > R_HI) begin
      res_value = DW'(R_HI);
      res_sat   = 1'b1;
    end else if (res_full < R_LO) begin
      res_value = DW'(R_LO);
      res_sat   = 1'b1;
    end else begin
      res_value = DW'(res_full);
      res_sat   = 1'b0;
    end
  end

  assign res_valid = valid_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r[1] <= in_func;
      xv_r[1]   <= in_x;
      gv_r[1]   <= in_grad;
      xq_r[1]   <= xq_nxt;
      for (int i = 2; i <= NST; i++) begin
        func_r[i] <= func_r[i-1];
        gv_r[i]   <= gv_r[i-1];
      end
      for (int i = 2; i <= 7; i++) begin
        xv_r[i] <= xv_r[i-1];
      end
      for (int i = 2; i <= 10; i++) begin
        xq_r[i] <= xq_r[i-1];
      end
      pl_r[3] <= pl_nxt;
      for (int i = 4; i <= 9; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
      h_r[8]  <= h_nxt;
      h_r[9]  <= h_r[8];
      h_r[10] <= h_r[9];
      fw_r[8] <= fw_nxt;
      for (int i = 9; i <= NST; i++) begin
        fw_r[i] <= fw_r[i-1];
      end
      x2_r    <= x2_nxt;
      x3_r    <= x3_nxt;
      u_r     <= u_nxt;
      inner_r <= inner_nxt;
      neg_r   <= neg_nxt;
      big_r   <= big_nxt;
      tk_r    <= tk_nxt;
      dt_r    <= dt_nxt;
      fr_r    <= fr_nxt;
      t_r     <= t_nxt;
      s2_r    <= s2_nxt;
      sc_r    <= sc_nxt;
      q_r     <= q_nxt;
      d_r     <= d_nxt;
    end
  end

endmodule

[rtl/gtd_skid.sv]
module gtd_skid #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  input  logic [WIDTH-1:0] s_data,
  output logic             s_ready,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);

  logic             out_v_r;
  logic             out_v_nxt;
  logic [WIDTH-1:0] out_d_r;
  logic [WIDTH-1:0] out_d_nxt;
  logic             skid_v_r;
  logic             skid_v_nxt;
  logic [WIDTH-1:0] skid_d_r;
  logic [WIDTH-1:0] skid_d_nxt;
  logic             take;

  assign s_ready = !skid_v_r;
  assign take    = s_valid && !skid_v_r;
  assign m_valid = out_v_r;
  assign m_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (m_ready || !out_v_r) begin
      // output register free: drain skid first, else take the new beat
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = take;
        out_d_nxt = s_data;
      end
    end else if (take) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

[rtl/gelu_tanh_with_derivative_top.sv]
// GELU (tanh form) and its derivative, one element per beat.
// Pipeline: 11 arithmetic stages, at most one multiply deep each, then the output register.
// Throughput: one beat per cycle while the skid is empty; a stalled output parks one
// result in a skid register so in_tready is a flop and never waits on out_tready.
// Reset: synchronous, active low; clears every valid bit, data is left as is.
module gelu_tanh_with_derivative_top #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TANH_SEGMENTS = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [DATA_WIDTH-1:0] x, [2*DATA_WIDTH-1:DATA_WIDTH] grad, zero padded
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       in_tdata,
  // [0] func: 0 forward, 1 backward
  input  logic                                    in_tuser,
  // result channel
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [DATA_WIDTH-1:0] value, zero padded
  output logic [((DATA_WIDTH+7)/8)*8-1:0]         out_tdata,
  // [0] saturated
  output logic                                    out_tuser
);

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  logic                 en;
  logic                 res_valid;
  logic [DW-1:0]        res_value;
  logic                 res_sat;
  logic [DW:0]          out_pack;

  // The whole pipeline moves when the skid register is empty; the skid
  // holds the one beat that may leave the core during a stall.
  assign in_tready = en;

  gtd_core #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .TANH_SEGMENTS (TANH_SEGMENTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_x      ($signed(in_tdata[DW-1:0])),
    .in_grad   ($signed(in_tdata[2*DW-1:DW])),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  gtd_skid #(
    .WIDTH (DW + 1)
  ) u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_data  ({res_sat, res_value}),
    .s_ready (en),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_pack)
  );

  assign out_tdata = OUT_W'(out_pack[DW-1:0]);
  assign out_tuser = out_pack[DW];

endmodule

[rtl/gtd_checker.sv]
module gtd_checker #(
  parameter int DATA_WIDTH    = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  input logic                              out_tuser
);

  localparam logic [DATA_WIDTH-1:0] V_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] V_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input beat changed while stalled");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input side only blocks while a result is parked at the output
  a_block_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with no result pending");

  // input side only starts blocking after an output stall
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input blocked without output back-pressure");

  // saturation flag only with a clipped value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[DATA_WIDTH-1:0] == V_MAX || out_tdata[DATA_WIDTH-1:0] == V_MIN)
    else $error("saturated set on an unclipped value");

endmodule

bind gelu_tanh_with_derivative_top gtd_checker #(
  .DATA_WIDTH    (DATA_WIDTH)
) u_gtd_checker (.*);

[test/gelu_tanh_with_derivative_top_test.sv]
`timescale 1ns / 1ps

module gelu_tanh_with_derivative_top_test;
  import gtd_pkg::func_t;
  import gtd_pkg::FUNC_FWD;
  import gtd_pkg::FUNC_BWD;

  localparam int     SEGS       = 256;
  localparam int     IDLE_LIMIT = 2000;    // cycles with no beat on either side
  localparam int     DRAIN      = 24;      // extra wait at the end of the run
  localparam longint Q30        = 64'sd1073741824;
  localparam longint SQRT2PI    = 64'sd856722024;  // sqrt(2/pi), Q30
  localparam longint CUBIC      = 64'sd48012366;   // 0.044715, Q30
  localparam longint CUBIC3     = 64'sd144037097;  // 3*0.044715, Q30
  localparam longint X_LIM      = 64'sd32768;      // 8.0 in Q4.12
  localparam longint OUT_MAX    = 64'sd32767;
  localparam longint OUT_MIN    = -64'sd32768;

  // one element in, one result out
  typedef struct {
    func_t             func;
    logic signed [15:0] x;
    logic signed [15:0] grad;
  } elem_t;

  typedef struct {
    logic signed [15:0] value;
    logic               sat;
  } act_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] x, [31:16] grad
  logic        in_tuser   = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] value
  logic        out_tuser;         // [0] saturated

  elem_t  stim_q[$];      // elements waiting to be sent
  act_t   expected_q[$];  // results owed by the block, oldest first
  longint tanh_q30[0:SEGS];

  elem_t  cur_elem;
  int     src_gap    = 0;
  bit     src_burst  = 1'b0;
  int     sink_stall = 0;
  bit     sink_burst = 1'b0;
  int     idle_cycles = 0;
  int     errors = 0;

  gelu_tanh_with_derivative_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // add half an LSB, then floor
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // exp(-f), f in Q30 within [0, 1.0], 24-term series
  function automatic longint exp_neg_q30(longint f);
    longint term;
    longint sum;
    term = Q30;
    sum  = Q30;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * f) >>> 30) / i;
      sum  = (i % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // tanh(8k/SEGS) as (1-e)/(1+e), e = exp(-2u); kept non-decreasing
  function automatic void build_tanh_table();
    longint e1;
    longint y;
    longint e;
    longint th;
    e1 = exp_neg_q30(Q30);
    for (int k = 0; k <= SEGS; k++) begin
      y = (longint'(k) << 34) / SEGS;
      e = exp_neg_q30(y & (Q30 - 1));
      for (longint i = 0; i < (y >>> 30); i++) begin
        e = (e * e1) >>> 30;
      end
      th = ((Q30 - e) * Q30) / (Q30 + e);
      if (k > 0 && th < tanh_q30[k-1]) begin
        th = tanh_q30[k-1];
      end
      tanh_q30[k] = th;
    end
  endfunction

  // argument Q24, result Q30; flat at +-1 from |arg| = 8 on
  function automatic longint tanh_lookup(longint arg);
    longint m;
    longint p;
    longint fr;
    longint r;
    int     k;
    m = (arg < 0) ? -arg : arg;
    if (m >= (longint'(8) << 24)) begin
      r = Q30;
    end else begin
      p  = m * SEGS;
      k  = int'(p >>> 27);
      fr = p & ((longint'(1) << 27) - 1);
      r  = tanh_q30[k] + round_shift((tanh_q30[k+1] - tanh_q30[k]) * fr, 27);
    end
    return (arg < 0) ? -r : r;
  endfunction

  function automatic act_t gelu_predict(elem_t e);
    longint xv, gv, xc, xq, x2, x3, arg, t, res;
    longint s2, h, pl, q, d;
    act_t   r;
    xv  = longint'(e.x);
    gv  = longint'(e.grad);
    xc  = (xv > X_LIM) ? X_LIM : ((xv < -X_LIM) ? -X_LIM : xv);
    xq  = xc * 4096;  // Q12 -> Q24
    x2  = round_shift(xq * xq, 24);
    x3  = round_shift(x2 * xq, 24);
    arg = round_shift(SQRT2PI * (xq + round_shift(CUBIC * x3, 30)), 30);
    t   = tanh_lookup(arg);
    if (e.func == FUNC_FWD) begin
      res = round_shift(xv * (Q30 + t), 31);
    end else begin
      // (1+t)/2 plus x/2 * (1-t^2) * c * (1 + 3a x^2), all Q24
      s2  = Q30 - round_shift(t * t, 30);
      h   = round_shift(Q30 + t, 7);
      pl  = (longint'(1) << 24) + round_shift(CUBIC3 * x2, 30);
      q   = round_shift(round_shift(s2 * SQRT2PI, 30) * pl, 30);
      d   = h + round_shift(q * xq, 25);
      res = round_shift(gv * d, 24);
    end
    r.sat = 1'b0;
    if (res > OUT_MAX) begin
      res   = OUT_MAX;
      r.sat = 1'b1;
    end else if (res < OUT_MIN) begin
      res   = OUT_MIN;
      r.sat = 1'b1;
    end
    r.value = 16'(res);
    return r;
  endfunction

  task automatic add_elem(func_t f, int x, int g);
    stim_q.push_back(elem_t'{f, 16'(x), 16'(g)});
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one element per beat, random gap drawn per element.
  // The prediction is made the moment a beat is taken, so expected_q always
  // mirrors what is inside the pipeline.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(gelu_predict(cur_elem));
      end
      // only move on once the current beat has gone (or none is offered)
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_elem = stim_q.pop_front();
          in_tdata  <= {cur_elem.grad, cur_elem.x};
          in_tuser  <= cur_elem.func;
          in_tvalid <= 1'b1;
          // occasional back-to-back stretches with no gaps at all
          if ($urandom_range(0, 63) == 0) begin
            src_burst = ~src_burst;
          end
          src_gap = src_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and sink: checks each beat against the oldest expectation,
  // then holds tready low for a random stall before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    act_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: value %0d, saturated %0b",
                 $signed(out_tdata), out_tuser);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, $signed(out_tdata));
            errors++;
          end
          if (out_tuser !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, out_tuser);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) begin
          sink_burst = ~sink_burst;
        end
        sink_stall = sink_burst ? 0 : $urandom_range(0, 9);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int xs[11];
    int xr;
    int gr;
    int sel;
    build_tanh_table();

    // directed: range ends, zero, +-1 LSB, +-1.0, where tanh flattens out
    // (|x| around 3.4), and beyond it; backward runs each with full-scale grad
    xs = '{-32768, 32767, 0, 1, -1, 4096, -4096, 14000, -14000, 20480, -20480};
    foreach (xs[i]) begin
      add_elem(FUNC_FWD, xs[i], int'($urandom_range(0, 65535)));
      add_elem(FUNC_BWD, xs[i], (i % 2 == 0) ? 32767 : -32768);
    end
    add_elem(FUNC_BWD, 4096, 0);
    add_elem(FUNC_BWD, 6144, 32767);
    add_elem(FUNC_BWD, 1229, 4096);

    // random: mostly the curved region, some full range, some near zero
    for (int n = 0; n < 1250; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        xr = $urandom_range(0, 65535);
      end else if (sel < 9) begin
        xr = int'($urandom_range(0, 49152)) - 24576;
      end else begin
        xr = int'($urandom_range(0, 511)) - 256;
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        gr = $urandom_range(0, 65535);
      end else if (sel < 8) begin
        gr = int'($urandom_range(0, 16384)) - 8192;
      end else if ($urandom_range(0, 1) == 1) begin
        gr = 32767 - int'($urandom_range(0, 4095));
      end else begin
        gr = -32768 + int'($urandom_range(0, 4095));
      end
      add_elem(func_t'($urandom_range(0, 1)), xr, gr);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so queue state is settled
    do begin
      @(negedge clk);
    end while (stim_q.size() != 0 || in_tvalid || expected_q.size() != 0);
    repeat (DRAIN) @(negedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
